// File: sv/wsro_pkg.sv
`timescale 1ns / 1ps

package wsro_pkg;

  localparam int NUM_WHEELS_DEF = 6;

  localparam int STAMP_W    = 48;
  localparam int WIDX_W     = 3;
  localparam int VAL_W      = 32;
  localparam int ANG_W      = 16;
  localparam int RATIO_W    = 16;
  localparam int IN_DATA_W  = 264;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int TRIG_W     = 18;

  localparam logic               ENABLE_RST    = 1'b1;
  localparam logic [23:0]        TIMEOUT_RST   = 24'd500000;
  localparam logic [15:0]        MAX_SLIP_RST  = 16'd52429;
  localparam logic [30:0]        MIN_SPEED_RST = 31'd655;
  localparam logic [15:0]        DEADBAND_RST  = 16'd655;
  localparam logic [15:0]        SLIP_CEIL     = 16'd64880;

  localparam logic signed [20:0] Q16_PI      = 21'sd205887;
  localparam logic signed [20:0] Q16_HALF_PI = 21'sd102944;
  localparam logic signed [20:0] Q16_TWO_PI  = 21'sd411775;
  localparam logic signed [19:0] CORDIC_K    = 20'sd39797;
  localparam logic signed [19:0] TRIG_ONE    = 20'sd65536;
  localparam logic signed [65:0] TERM_LIMIT  = 66'sd70368744177663;

  typedef enum logic [1:0] {
    KIND_REF   = 2'd0,
    KIND_WHEEL = 2'd1,
    KIND_POS   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CFG_ENABLE    = 3'd0,
    CFG_TIMEOUT   = 3'd1,
    CFG_MAX_SLIP  = 3'd2,
    CFG_MIN_SPEED = 3'd3,
    CFG_DEADBAND  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MUL,
    ST_DIV,
    ST_QUOT,
    ST_FINISH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } sincos_t;

  function automatic logic signed [20:0] atan_q16(input logic [3:0] idx);
    logic signed [20:0] v;
    case (idx)
      4'd0:    v = 21'sd51472;
      4'd1:    v = 21'sd30386;
      4'd2:    v = 21'sd16055;
      4'd3:    v = 21'sd8150;
      4'd4:    v = 21'sd4091;
      4'd5:    v = 21'sd2047;
      4'd6:    v = 21'sd1024;
      4'd7:    v = 21'sd512;
      4'd8:    v = 21'sd256;
      4'd9:    v = 21'sd128;
      4'd10:   v = 21'sd64;
      4'd11:   v = 21'sd32;
      4'd12:   v = 21'sd16;
      4'd13:   v = 21'sd8;
      4'd14:   v = 21'sd4;
      default: v = 21'sd2;
    endcase
    return v;
  endfunction

endpackage

// File: sv/wsro_cordic.sv
`timescale 1ns / 1ps

module wsro_cordic import wsro_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ANG_W-1:0] angle,
  output sincos_t                 sc
);

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [3:0]               it_r, it_nxt;
  logic signed [19:0]       x_r, x_nxt;
  logic signed [19:0]       y_r, y_nxt;
  logic signed [20:0]       z_r, z_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [TRIG_W-1:0] cos_r, cos_nxt;
  logic signed [TRIG_W-1:0] sin_r, sin_nxt;

  logic signed [20:0] z0, zw;
  logic signed [19:0] dx, dy, xi, yi;

  function automatic logic signed [TRIG_W-1:0] clamp_trig(input logic signed [19:0] v);
    logic signed [19:0] r;
    if (v > TRIG_ONE) r = TRIG_ONE;
    else if (v < -TRIG_ONE) r = -TRIG_ONE;
    else r = v;
    return TRIG_W'(r);
  endfunction

  always_comb begin
    z0 = {angle[ANG_W-1], angle, 4'd0};
    if (z0 > Q16_PI) zw = z0 - Q16_TWO_PI;
    else if (z0 < -Q16_PI) zw = z0 + Q16_TWO_PI;
    else zw = z0;
    dx = y_r >>> it_r;
    dy = x_r >>> it_r;
    if (z_r >= 0) begin
      xi = x_r - dx;
      yi = y_r + dy;
    end else begin
      xi = x_r + dx;
      yi = y_r - dy;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    it_nxt   = it_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    neg_nxt  = neg_r;
    cos_nxt  = cos_r;
    sin_nxt  = sin_r;
    if (start) begin
      busy_nxt = 1'b1;
      it_nxt   = '0;
      x_nxt    = CORDIC_K;
      y_nxt    = '0;
      if (zw > Q16_HALF_PI) begin
        z_nxt   = zw - Q16_PI;
        neg_nxt = 1'b1;
      end else if (zw < -Q16_HALF_PI) begin
        z_nxt   = zw + Q16_PI;
        neg_nxt = 1'b1;
      end else begin
        z_nxt   = zw;
        neg_nxt = 1'b0;
      end
    end else if (busy_r) begin
      x_nxt  = xi;
      y_nxt  = yi;
      z_nxt  = (z_r >= 0) ? z_r - atan_q16(it_r) : z_r + atan_q16(it_r);
      it_nxt = it_r + 4'd1;
      if (it_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        cos_nxt  = clamp_trig(neg_r ? -xi : xi);
        sin_nxt  = clamp_trig(neg_r ? -yi : yi);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      it_r   <= it_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    neg_r <= neg_nxt;
    cos_r <= cos_nxt;
    sin_r <= sin_nxt;
  end

  assign sc = '{done: done_r, cos_v: cos_r, sin_v: sin_r};

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("sincos restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("sincos done without run");
  a_iter_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r && !start |=> !busy_r) else $error("sincos started spontaneously");
`endif

endmodule

// File: sv/wheel_slip_ratio_observer.sv
`timescale 1ns / 1ps

// Wheel slip ratio observer. Beat kind 0 stores the visual twist and its stamp,
// kind 2 loads a wheel position, kind 1 is a wheel sample whose slip ratio is
// computed against the stored twist; on the last sample of a joint message the
// block sends NUM_WHEELS result beats if any wheel was observed. A reference or
// position beat leaves the block idle. A wheel sample that fails the gate or
// speed test goes straight to the finish state; a full sample runs 16 iterations
// of the sine/cosine unit, 10 steps on the one shared 33x33 multiplier and,
// outside the deadband, 16 steps of the restoring divider. Result beats go out
// back to back while the output side is ready. in_tready is low while a sample
// is processed or results are sent; configuration is always accepted.
module wheel_slip_ratio_observer import wsro_pkg::*; #(
  parameter int NUM_WHEELS = NUM_WHEELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // stamp, wheel_index, wheel_speed, steer_angle, vel_x, vel_y, yaw_rate,
  // pos_x, pos_y, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic [1:0]            in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_wheel, slip_ratio, observed, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int KW = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(NUM_WHEELS - 1);

  function automatic logic signed [46:0] clamp_term(input logic signed [65:0] v);
    logic signed [65:0] r;
    if (v > TERM_LIMIT) r = TERM_LIMIT;
    else if (v < -TERM_LIMIT) r = -TERM_LIMIT;
    else r = v;
    return 47'(r);
  endfunction

  // beat fields
  logic [STAMP_W-1:0]      in_stamp;
  logic [WIDX_W-1:0]       in_widx;
  logic signed [VAL_W-1:0] in_speed, in_vx, in_vy, in_wz, in_px, in_py;
  logic signed [ANG_W-1:0] in_steer;

  assign in_stamp = in_tdata[47:0];
  assign in_widx  = in_tdata[50:48];
  assign in_speed = in_tdata[82:51];
  assign in_steer = in_tdata[98:83];
  assign in_vx    = in_tdata[130:99];
  assign in_vy    = in_tdata[162:131];
  assign in_wz    = in_tdata[194:163];
  assign in_px    = in_tdata[226:195];
  assign in_py    = in_tdata[258:227];

  state_t state_r, state_nxt;

  logic        enable_r;
  logic [23:0] timeout_r;
  logic [15:0] max_slip_r;
  logic [30:0] min_speed_r;
  logic [15:0] deadband_r;

  logic                     ref_present_r, ref_present_nxt;
  logic [STAMP_W-1:0]       ref_stamp_r, ref_stamp_nxt;
  logic signed [VAL_W-1:0]  ref_vx_r, ref_vx_nxt, ref_vy_r, ref_vy_nxt, ref_wz_r, ref_wz_nxt;
  logic [STAMP_W-1:0]       used_stamp_r, used_stamp_nxt;
  logic signed [VAL_W-1:0]  wx_r [NUM_WHEELS];
  logic signed [VAL_W-1:0]  wx_nxt [NUM_WHEELS];
  logic signed [VAL_W-1:0]  wy_r [NUM_WHEELS];
  logic signed [VAL_W-1:0]  wy_nxt [NUM_WHEELS];
  logic [RATIO_W-1:0]       pend_ratio_r [NUM_WHEELS];
  logic [RATIO_W-1:0]       pend_ratio_nxt [NUM_WHEELS];
  logic [NUM_WHEELS-1:0]    pend_valid_r, pend_valid_nxt;
  logic                     any_obs_r, any_obs_nxt;

  logic [KW-1:0]            widx_r, widx_nxt;
  logic                     last_r, last_nxt;
  logic signed [VAL_W-1:0]  speed_r, speed_nxt;
  logic [VAL_W-1:0]         sp_r, sp_nxt;
  logic [3:0]               step_r, step_nxt;
  logic signed [46:0]       t1_r, t1_nxt, t2_r, t2_nxt;
  logic signed [65:0]       acc_r, acc_nxt;
  logic signed [65:0]       mul_r;
  logic                     rej_r, rej_nxt;
  logic [VAL_W-1:0]         ex_r, ex_nxt;
  logic [32:0]              rem_r, rem_nxt;
  logic [16:0]              q_r, q_nxt;
  logic [KW-1:0]            k_r, k_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [WIDX_W-1:0]        out_wheel_r, out_wheel_nxt;
  logic [RATIO_W-1:0]       out_ratio_r, out_ratio_nxt;
  logic                     out_obs_r, out_obs_nxt;
  logic                     out_last_r, out_last_nxt;

  logic                     in_fire, in_range, gate_ok, speed_ok, ok_pre;
  logic [KW-1:0]            in_wsel;
  logic [STAMP_W-1:0]       gap;
  logic [VAL_W-1:0]         in_sp;
  logic                     cordic_start;
  sincos_t                  sc;
  logic signed [32:0]       mul_a, mul_b;
  logic signed [65:0]       mul_p;
  logic [15:0]              lim;
  logic [47:0]              num;
  logic signed [65:0]       expv, ex_abs;
  logic                     rej_now, dead, qbit, ge, emit_load;
  logic [32:0]              r2;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_range = ({29'd0, in_widx} < 32'(NUM_WHEELS));
    in_wsel  = KW'(in_widx);
    gap      = (in_stamp >= ref_stamp_r) ? in_stamp - ref_stamp_r : ref_stamp_r - in_stamp;
    gate_ok  = enable_r && ref_present_r && (gap <= {24'd0, timeout_r}) &&
               (ref_stamp_r > used_stamp_r);
    in_sp    = in_speed[VAL_W-1] ? VAL_W'(-in_speed) : VAL_W'(in_speed);
    speed_ok = (in_speed != '0) && (in_sp >= {1'b0, min_speed_r});
    ok_pre   = in_range && gate_ok && speed_ok;
    lim      = (max_slip_r > SLIP_CEIL) ? SLIP_CEIL : max_slip_r;
    num      = {ex_r[31:0], 16'd0};
    expv     = acc_r >>> 16;
    ex_abs   = expv[65] ? -expv : expv;
    rej_now  = rej_r || (mul_r[48:0] > {1'b0, num});
    dead     = (mul_r[48:0] < {1'b0, num});
    qbit     = (ex_r >= sp_r);
    r2       = {rem_r[31:0], 1'b0};
    ge       = (r2 >= {1'b0, sp_r});
    emit_load = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  end

  assign cordic_start = in_fire && (kind_t'(in_tuser) == KIND_WHEEL) && ok_pre;

  wsro_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .angle (in_steer),
    .sc    (sc)
  );

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_MUL) begin
      case (step_r)
        4'd0: begin
          mul_a = 33'(wy_r[widx_r]);
          mul_b = 33'(ref_wz_r);
        end
        4'd1: begin
          mul_a = 33'(wx_r[widx_r]);
          mul_b = 33'(ref_wz_r);
        end
        4'd2: begin
          mul_a = 33'(sc.cos_v);
          mul_b = {9'd0, t1_r[23:0]};
        end
        4'd3: begin
          mul_a = 33'(sc.cos_v);
          mul_b = 33'($signed(t1_r[46:24]));
        end
        4'd4: begin
          mul_a = 33'(sc.sin_v);
          mul_b = {9'd0, t2_r[23:0]};
        end
        4'd5: begin
          mul_a = 33'(sc.sin_v);
          mul_b = 33'($signed(t2_r[46:24]));
        end
        4'd7: begin
          mul_a = {16'd0, 17'h10000 - {1'b0, lim}};
          mul_b = {1'b0, sp_r};
        end
        4'd8: begin
          mul_a = {16'd0, 17'h10000 - {1'b0, deadband_r}};
          mul_b = {1'b0, sp_r};
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (kind_t'(in_tuser) == KIND_WHEEL)) begin
          state_nxt = ok_pre ? ST_CORDIC : ST_FINISH;
        end
      end
      ST_CORDIC: begin
        if (sc.done) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (step_r == 4'd8 && rej_now) state_nxt = ST_FINISH;
        else if (step_r == 4'd9) state_nxt = dead ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        if (step_r == 4'd15) state_nxt = ST_QUOT;
      end
      ST_QUOT:   state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = (last_r && any_obs_r) ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (emit_load && k_r == K_LAST) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    ref_present_nxt = ref_present_r;
    ref_stamp_nxt   = ref_stamp_r;
    ref_vx_nxt      = ref_vx_r;
    ref_vy_nxt      = ref_vy_r;
    ref_wz_nxt      = ref_wz_r;
    used_stamp_nxt  = used_stamp_r;
    wx_nxt          = wx_r;
    wy_nxt          = wy_r;
    pend_ratio_nxt  = pend_ratio_r;
    pend_valid_nxt  = pend_valid_r;
    any_obs_nxt     = any_obs_r;
    widx_nxt        = widx_r;
    last_nxt        = last_r;
    speed_nxt       = speed_r;
    sp_nxt          = sp_r;
    step_nxt        = step_r;
    t1_nxt          = t1_r;
    t2_nxt          = t2_r;
    acc_nxt         = acc_r;
    rej_nxt         = rej_r;
    ex_nxt          = ex_r;
    rem_nxt         = rem_r;
    q_nxt           = q_r;
    k_nxt           = k_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_wheel_nxt   = out_wheel_r;
    out_ratio_nxt   = out_ratio_r;
    out_obs_nxt     = out_obs_r;
    out_last_nxt    = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (kind_t'(in_tuser))
            KIND_REF: begin
              ref_stamp_nxt   = in_stamp;
              ref_vx_nxt      = in_vx;
              ref_vy_nxt      = in_vy;
              ref_wz_nxt      = in_wz;
              ref_present_nxt = 1'b1;
            end
            KIND_POS: begin
              if (in_range) begin
                wx_nxt[in_wsel] = in_px;
                wy_nxt[in_wsel] = in_py;
              end
            end
            KIND_WHEEL: begin
              widx_nxt  = in_wsel;
              last_nxt  = in_tlast;
              speed_nxt = in_speed;
              sp_nxt    = in_sp;
              step_nxt  = '0;
              if (in_range && !ok_pre) begin
                pend_valid_nxt[in_wsel] = 1'b0;
                pend_ratio_nxt[in_wsel] = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL: begin
        step_nxt = step_r + 4'd1;
        case (step_r)
          4'd1: t1_nxt = clamp_term(((66'(ref_vx_r) <<< 16) - mul_r) >>> 16);
          4'd2: t2_nxt = clamp_term(((66'(ref_vy_r) <<< 16) + mul_r) >>> 16);
          4'd3: acc_nxt = mul_r;
          4'd4: acc_nxt = acc_r + (mul_r <<< 24);
          4'd5: acc_nxt = acc_r + mul_r;
          4'd6: acc_nxt = acc_r + (mul_r <<< 24);
          4'd7: begin
            rej_nxt = (speed_r < 0 && expv > 0) || (speed_r > 0 && expv < 0) ||
                      (ex_abs > {34'd0, sp_r});
            ex_nxt  = ex_abs[31:0];
          end
          4'd8: begin
            if (rej_now) begin
              pend_valid_nxt[widx_r] = 1'b0;
              pend_ratio_nxt[widx_r] = '0;
            end
          end
          4'd9: begin
            step_nxt = '0;
            if (dead) begin
              pend_valid_nxt[widx_r] = 1'b1;
              pend_ratio_nxt[widx_r] = '0;
              any_obs_nxt            = 1'b1;
            end else begin
              q_nxt   = {16'd0, qbit};
              rem_nxt = {1'b0, ex_r - (qbit ? sp_r : '0)};
            end
          end
          default: begin
          end
        endcase
      end
      ST_DIV: begin
        step_nxt = step_r + 4'd1;
        rem_nxt  = ge ? r2 - {1'b0, sp_r} : r2;
        q_nxt    = {q_r[15:0], ge};
      end
      ST_QUOT: begin
        pend_valid_nxt[widx_r] = 1'b1;
        pend_ratio_nxt[widx_r] = RATIO_W'(17'h10000 - (q_r + {16'd0, rem_r != '0}));
        any_obs_nxt            = 1'b1;
      end
      ST_FINISH: begin
        k_nxt = '0;
        if (last_r) begin
          if (any_obs_r) begin
            used_stamp_nxt = ref_stamp_r;
          end else begin
            pend_valid_nxt = '0;
            for (int i = 0; i < NUM_WHEELS; i++) pend_ratio_nxt[i] = '0;
          end
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          out_valid_nxt = 1'b1;
          out_wheel_nxt = WIDX_W'(k_r);
          out_obs_nxt   = pend_valid_r[k_r];
          out_ratio_nxt = pend_valid_r[k_r] ? pend_ratio_r[k_r] : '0;
          out_last_nxt  = (k_r == K_LAST);
          k_nxt         = k_r + KW'(1);
          if (k_r == K_LAST) begin
            pend_valid_nxt = '0;
            for (int i = 0; i < NUM_WHEELS; i++) pend_ratio_nxt[i] = '0;
            any_obs_nxt    = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    if (state_r == ST_FINISH && last_r && !any_obs_r) any_obs_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      enable_r      <= ENABLE_RST;
      timeout_r     <= TIMEOUT_RST;
      max_slip_r    <= MAX_SLIP_RST;
      min_speed_r   <= MIN_SPEED_RST;
      deadband_r    <= DEADBAND_RST;
      ref_present_r <= 1'b0;
      ref_stamp_r   <= '0;
      ref_vx_r      <= '0;
      ref_vy_r      <= '0;
      ref_wz_r      <= '0;
      used_stamp_r  <= '0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        wx_r[i]         <= '0;
        wy_r[i]         <= '0;
        pend_ratio_r[i] <= '0;
      end
      pend_valid_r  <= '0;
      any_obs_r     <= 1'b0;
      step_r        <= '0;
      k_r           <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ENABLE:    enable_r    <= cfg_data[0];
          CFG_TIMEOUT:   timeout_r   <= cfg_data[23:0];
          CFG_MAX_SLIP:  max_slip_r  <= cfg_data[15:0];
          CFG_MIN_SPEED: min_speed_r <= cfg_data[30:0];
          CFG_DEADBAND:  deadband_r  <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      ref_present_r <= ref_present_nxt;
      ref_stamp_r   <= ref_stamp_nxt;
      ref_vx_r      <= ref_vx_nxt;
      ref_vy_r      <= ref_vy_nxt;
      ref_wz_r      <= ref_wz_nxt;
      used_stamp_r  <= used_stamp_nxt;
      wx_r          <= wx_nxt;
      wy_r          <= wy_nxt;
      pend_ratio_r  <= pend_ratio_nxt;
      pend_valid_r  <= pend_valid_nxt;
      any_obs_r     <= any_obs_nxt;
      step_r        <= step_nxt;
      k_r           <= k_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    widx_r      <= widx_nxt;
    last_r      <= last_nxt;
    speed_r     <= speed_nxt;
    sp_r        <= sp_nxt;
    t1_r        <= t1_nxt;
    t2_r        <= t2_nxt;
    acc_r       <= acc_nxt;
    mul_r       <= mul_p;
    rej_r       <= rej_nxt;
    ex_r        <= ex_nxt;
    rem_r       <= rem_nxt;
    q_r         <= q_nxt;
    out_wheel_r <= out_wheel_nxt;
    out_ratio_r <= out_ratio_nxt;
    out_obs_r   <= out_obs_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_obs_r, out_ratio_r, out_wheel_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !in_tready) else $error("input taken during emission");
  a_finish_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && last_r && any_obs_r) |=> (state_r == ST_EMIT))
    else $error("message end with observation did not emit");
  a_cordic_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sc.done |-> (state_r == ST_CORDIC)) else $error("sincos result out of sequence");
  a_wheel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({29'd0, out_wheel_r} < 32'(NUM_WHEELS)))
    else $error("result wheel out of range");
`endif

endmodule

// File: dv/wheel_slip_ratio_observer_tb.sv
`timescale 1ns / 1ps

module wheel_slip_ratio_observer_tb;
  import wsro_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int NW = NUM_WHEELS_DEF;
  localparam int IDLE_TAIL = 80;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [1:0]         kind;
    logic [47:0]        stamp;
    logic [2:0]         widx;
    logic signed [31:0] speed;
    logic signed [15:0] steer;
    logic               last;
    logic signed [31:0] vx, vy, wz, px, py;
  } beat_t;

  typedef struct {
    logic [2:0]  wheel;
    logic [15:0] ratio;
    logic        obs;
    logic        last;
  } slip_t;

  class slip_scoreboard;
    logic        en;
    logic [23:0] timeout;
    logic [15:0] max_slip;
    logic [30:0] min_speed;
    logic [15:0] deadband;
    logic        ref_ok;
    logic [47:0] ref_stamp, used_stamp;
    longint      ref_vx, ref_vy, ref_wz;
    longint      pos_x[NW], pos_y[NW];
    logic [15:0] pend_ratio[NW];
    logic        pend_obs[NW];
    logic        any_obs;
    slip_t       slip_q[$];
    int          errors, n_in, n_out, n_obs;

    function new();
      en = ENABLE_RST; timeout = TIMEOUT_RST; max_slip = MAX_SLIP_RST;
      min_speed = MIN_SPEED_RST; deadband = DEADBAND_RST;
      ref_ok = 0; ref_stamp = 0; used_stamp = 0;
      ref_vx = 0; ref_vy = 0; ref_wz = 0; any_obs = 0;
      for (int i = 0; i < NW; i++) begin
        pos_x[i] = 0; pos_y[i] = 0; pend_ratio[i] = 0; pend_obs[i] = 0;
      end
      errors = 0; n_in = 0; n_out = 0; n_obs = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    function void write_reg(cfg_idx_t idx, logic [30:0] v);
      case (idx)
        CFG_ENABLE:    en = v[0];
        CFG_TIMEOUT:   timeout = v[23:0];
        CFG_MAX_SLIP:  max_slip = v[15:0];
        CFG_MIN_SPEED: min_speed = v;
        CFG_DEADBAND:  deadband = v[15:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void sincos(longint ang, output longint c, output longint s);
      longint z, x, y, dx, dy;
      bit neg;
      longint atan_tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                               256, 128, 64, 32, 16, 8, 4, 2};
      z = ang * 16; x = 39797; y = 0; neg = 0;
      while (z > 205887) z -= 411775;
      while (z < -205887) z += 411775;
      if (z > 102944) begin
        z -= 205887; neg = 1;
      end else if (z < -102944) begin
        z += 205887; neg = 1;
      end
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i; dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
      if (neg) begin
        x = -x; y = -y;
      end
      c = clip(x, 65536);
      s = clip(y, 65536);
    endfunction

    function bit gate(logic [47:0] st);
      logic [47:0] gap;
      if (!en || !ref_ok) return 0;
      gap = (st >= ref_stamp) ? st - ref_stamp : ref_stamp - st;
      if (gap > {24'd0, timeout}) return 0;
      return ref_stamp > used_stamp;
    endfunction

    function bit slip_of(int w, longint spd, longint ang, output logic [15:0] r);
      longint c, s, t1, t2, ex_v, sp, ex, lim, num, q;
      r = 0;
      if (spd == 0) return 0;
      sp = spd < 0 ? -spd : spd;
      if (sp < longint'(min_speed)) return 0;
      sincos(ang, c, s);
      t1 = clip((ref_vx * 65536 - pos_y[w] * ref_wz) >>> 16, 64'sd70368744177663);
      t2 = clip((ref_vy * 65536 + pos_x[w] * ref_wz) >>> 16, 64'sd70368744177663);
      ex_v = (c * t1 + s * t2) >>> 16;
      if ((spd < 0 && ex_v > 0) || (spd > 0 && ex_v < 0)) return 0;
      ex = ex_v < 0 ? -ex_v : ex_v;
      if (ex > sp) return 0;
      lim = max_slip > SLIP_CEIL ? longint'(SLIP_CEIL) : longint'(max_slip);
      num = ex * 65536;
      if ((65536 - lim) * sp > num) return 0;
      if ((65536 - longint'(deadband)) * sp < num) r = 0;
      else begin
        q = (num + sp - 1) / sp;
        r = 16'(65536 - q);
      end
      return 1;
    endfunction

    function void note_beat(beat_t b);
      logic [15:0] r;
      bit ok;
      slip_t e;
      n_in++;
      case (b.kind)
        KIND_REF: begin
          ref_stamp = b.stamp; ref_vx = b.vx; ref_vy = b.vy; ref_wz = b.wz; ref_ok = 1;
        end
        KIND_POS: if (b.widx < NW) begin
          pos_x[b.widx] = b.px; pos_y[b.widx] = b.py;
        end
        KIND_WHEEL: begin
          if (b.widx < NW) begin
            ok = gate(b.stamp);
            if (ok) ok = slip_of(b.widx, b.speed, b.steer, r);
            pend_obs[b.widx] = ok;
            pend_ratio[b.widx] = ok ? r : 16'd0;
            if (ok) any_obs = 1;
          end
          if (b.last) begin
            if (any_obs) begin
              for (int k = 0; k < NW; k++) begin
                e.wheel = 3'(k); e.ratio = pend_ratio[k];
                e.obs = pend_obs[k]; e.last = (k == NW - 1);
                slip_q.push_back(e);
              end
              used_stamp = ref_stamp;
            end
            for (int k = 0; k < NW; k++) begin
              pend_obs[k] = 0; pend_ratio[k] = 0;
            end
            any_obs = 0;
          end
        end
        default: ;
      endcase
    endfunction

    task check_slip(slip_t got);
      slip_t e;
      n_out++;
      if (got.obs) n_obs++;
      if (slip_q.size() == 0) begin
        report($sformatf("unexpected beat wheel %0d", got.wheel));
        return;
      end
      e = slip_q.pop_front();
      if (got.wheel !== e.wheel)
        report($sformatf("wheel got %0d exp %0d", got.wheel, e.wheel));
      if (got.ratio !== e.ratio)
        report($sformatf("wheel %0d ratio got %0d exp %0d", e.wheel, got.ratio, e.ratio));
      if (got.obs !== e.obs)
        report($sformatf("wheel %0d observed got %0b exp %0b", e.wheel, got.obs, e.obs));
      if (got.last !== e.last)
        report($sformatf("wheel %0d tlast got %0b exp %0b", e.wheel, got.last, e.last));
    endtask
  endclass

  logic                  clk, rst_n;
  logic                  in_tvalid, in_tready, in_tlast;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid, out_tready, out_tlast;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  slip_scoreboard sb = new();
  bit calm = 0;
  bit hold_req = 0;
  int stall_cnt = 0;
  logic [47:0] tick = 48'd1000;

  wheel_slip_ratio_observer u_top (.*);

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  always @(posedge clk) begin
    beat_t b;
    slip_t r;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        b.kind = in_tuser; b.last = in_tlast;
        b.stamp = in_tdata[47:0]; b.widx = in_tdata[50:48];
        b.speed = in_tdata[82:51]; b.steer = in_tdata[98:83];
        b.vx = in_tdata[130:99]; b.vy = in_tdata[162:131];
        b.wz = in_tdata[194:163]; b.px = in_tdata[226:195];
        b.py = in_tdata[258:227];
        sb.note_beat(b);
      end
      if (out_tvalid && out_tready) begin
        r.wheel = out_tdata[2:0]; r.ratio = out_tdata[18:3];
        r.obs = out_tdata[19]; r.last = out_tlast;
        sb.check_slip(r);
      end
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_idx_t'(cfg_index), cfg_data);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        stall_cnt <= 0;
      else
        stall_cnt <= stall_cnt + 1;
      if (stall_cnt == STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send(beat_t b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= b.kind;
    in_tlast  <= b.last;
    in_tdata  <= {5'd0, b.py, b.px, b.wz, b.vy, b.vx, b.steer, b.speed, b.widx, b.stamp};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.slip_q.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [30:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic beat_t mk(logic [1:0] kind, logic [47:0] st, logic [2:0] w,
                               logic [31:0] spd, logic [15:0] ang, logic lst);
    beat_t b;
    b.kind = kind; b.stamp = st; b.widx = w; b.speed = spd; b.steer = ang;
    b.last = lst; b.vx = '0; b.vy = '0; b.wz = '0; b.px = '0; b.py = '0;
    return b;
  endfunction

  function automatic beat_t mk_ref(logic [47:0] st, logic [31:0] vx, vy, wz);
    beat_t b = mk(KIND_REF, st, '0, '0, '0, 1'b0);
    b.vx = vx; b.vy = vy; b.wz = wz;
    return b;
  endfunction

  function automatic beat_t mk_pos(logic [2:0] w, logic [31:0] x, y);
    beat_t b = mk(KIND_POS, '0, w, '0, '0, 1'b0);
    b.px = x; b.py = y;
    return b;
  endfunction

  function automatic beat_t noise();
    beat_t b;
    b.kind = 2'($urandom_range(0, 3));
    if (b.kind == KIND_REF) b.kind = KIND_SPARE;
    b.stamp = {$urandom(), $urandom()};
    b.widx = 3'($urandom_range(0, 7));
    b.speed = $urandom(); b.steer = 16'($urandom()); b.last = 1'($urandom_range(0, 1));
    b.vx = $urandom(); b.vy = $urandom(); b.wz = $urandom();
    b.px = $urandom(); b.py = $urandom();
    if (b.kind == KIND_POS && b.widx < NW) b.widx = 3'd7;
    return b;
  endfunction

  function automatic logic signed [31:0] small_signed(int mag);
    return $signed($urandom_range(0, 2 * mag)) - mag;
  endfunction

  task automatic load_positions();
    for (int w = 0; w < NW; w++)
      send(mk_pos(3'(w), small_signed(65536), small_signed(65536)));
  endtask

  task automatic send_message(int tight);
    longint vx, spd;
    logic [47:0] js;
    int order[NW];
    beat_t b;
    tick += $urandom_range(100, 5000);
    vx = $urandom_range(30000, 1500000);
    if ($urandom_range(0, 1)) vx = -vx;
    if ($urandom_range(0, 9) == 0)
      send(mk_ref(tick, $urandom(), $urandom(), $urandom()));
    else
      send(mk_ref(tick, 32'(vx), small_signed(3000), small_signed(20000)));
    for (int i = 0; i < NW; i++) order[i] = i;
    if ($urandom_range(0, 3) == 0) order.shuffle();
    if ($urandom_range(0, 4) == 0) order[$urandom_range(0, NW - 2)] = order[NW - 1];
    for (int i = 0; i < NW; i++) begin
      js = tight ? tick : tick + $urandom_range(0, 4000);
      spd = vx + vx * (longint'($urandom_range(0, 450)) - 30) / 1000;
      if ($urandom_range(0, 15) == 0) spd = $signed($urandom());
      b = mk(KIND_WHEEL, js, 3'(order[i]), 32'(spd), 16'(small_signed(600)), i == NW - 1);
      if ($urandom_range(0, 15) == 0) b.steer = 16'($urandom());
      send(b);
    end
  endtask

  task automatic run_phase(int msgs, int tight);
    for (int m = 0; m < msgs; m++) begin
      if ($urandom_range(0, 4) == 0) send(noise());
      send_message(tight);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0; in_tdata <= '0; in_tuser <= '0; in_tlast <= 1'b0;
    cfg_valid <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int w = 0; w < NW; w++) send(mk_pos(3'(w), 32'sd0, 32'sd0));
    send(mk_pos(3'd6, 32'h7fffffff, 32'h80000000));
    send(mk(KIND_WHEEL, 48'd500, 3'd0, 32'sd70000, 16'sd0, 1'b1));
    send(mk_ref(48'd1000, 32'sd65536, 32'sd0, 32'sd0));
    send(mk(KIND_WHEEL, 48'd1000, 3'd0, 32'sd70000, 16'sd0, 1'b0));
    send(mk(KIND_WHEEL, 48'd1000, 3'd1, 32'sd0, 16'sd0, 1'b0));
    send(mk(KIND_WHEEL, 48'd1000, 3'd2, -32'sd70000, 16'sd0, 1'b0));
    send(mk(KIND_WHEEL, 48'd1000, 3'd3, 32'h7fffffff, 16'sd0, 1'b0));
    send(mk(KIND_WHEEL, 48'd1000, 3'd4, 32'sd65536, 16'sh7fff, 1'b0));
    send(mk(KIND_WHEEL, 48'd1000, 3'd5, 32'sd66000, 16'sh8000, 1'b0));
    send(mk(KIND_SPARE, 48'hffffffffffff, 3'd7, 32'hffffffff, 16'hffff, 1'b1));
    send(mk(KIND_WHEEL, 48'd1001, 3'd7, 32'sd66000, 16'sd0, 1'b1));
    send(mk(KIND_WHEEL, 48'd1001, 3'd0, 32'sd70000, 16'sd0, 1'b1));
    send(mk_ref(48'd5000, 32'sd65536, 32'sd0, 32'sd0));
    send(mk(KIND_WHEEL, 48'd605001, 3'd0, 32'sd70000, 16'sd0, 1'b1));
    send(mk_ref(48'd7000, -32'sd65536, 32'sd0, 32'sd0));
    send(mk(KIND_WHEEL, 48'd7000, 3'd0, -32'sd65600, 16'sd0, 1'b0));
    send(mk(KIND_WHEEL, 48'd7000, 3'd1, 32'h80000000, 16'sd0, 1'b0));
    send(mk(KIND_WHEEL, 48'd7000, 3'd2, -32'sd600, 16'sd0, 1'b1));
    load_positions();
    run_phase(6, 0);
    drain();

    write_reg(CFG_ENABLE, 31'd0);
    run_phase(3, 0);
    drain();

    write_reg(CFG_ENABLE, 31'd1);
    write_reg(CFG_TIMEOUT, 31'd0);
    write_reg(CFG_MAX_SLIP, 31'd65535);
    write_reg(CFG_MIN_SPEED, 31'd0);
    write_reg(CFG_DEADBAND, 31'd0);
    run_phase(6, 1);
    run_phase(3, 0);
    drain();

    write_reg(CFG_TIMEOUT, 31'd16777215);
    write_reg(CFG_MAX_SLIP, 31'd0);
    write_reg(CFG_MIN_SPEED, 31'h7fffffff);
    write_reg(CFG_DEADBAND, 31'd65535);
    run_phase(3, 0);
    drain();
    write_reg(CFG_MIN_SPEED, 31'd0);
    run_phase(3, 0);
    drain();

    write_reg(CFG_TIMEOUT, 31'd3000);
    write_reg(CFG_MAX_SLIP, 31'd30000);
    write_reg(CFG_MIN_SPEED, 31'd20000);
    write_reg(CFG_DEADBAND, 31'd2000);
    load_positions();
    hold_req = 1;
    run_phase(5, 0);
    drain();

    write_reg(CFG_TIMEOUT, 31'd500000);
    write_reg(CFG_MAX_SLIP, 31'd52429);
    write_reg(CFG_MIN_SPEED, 31'd655);
    write_reg(CFG_DEADBAND, 31'd655);
    run_phase(5, 0);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.slip_q.size() != 0) @(posedge clk);
    calm = 1;
    run_phase(5, 0);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.slip_q.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);

    $display("covered %0d input beats over six register settings, %0d result beats",
             sb.n_in, sb.n_out);
    $display("%0d wheels observed, %0d mismatches", sb.n_obs, sb.errors);
    if (sb.errors == 0 && sb.slip_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (sb.slip_q.size() != 0) $display("%0d result beats never arrived", sb.slip_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
